// ----- hw/rtl/spf_pkg.sv -----
// Shared types, constants and the micro-op table of the SPH pair force block.
// Used by the controller, the datapath and the top level.
package spf_pkg;

  localparam int FIELD_W = 48;
  localparam int UMAG_W  = 47;
  localparam int ACC_W   = 64;
  localparam int FRAC    = 24;
  localparam int TMP_W   = 63;
  localparam int OPD_W   = 64;
  localparam int PROD_W  = 128;
  localparam int RAD_W   = 96;
  localparam int ROOT_W  = 48;
  localparam int FLAG_W  = 2;
  localparam int PC_W    = 6;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;
  localparam int QUO_W   = TMP_W + FRAC;

  localparam logic [PC_W-1:0]   LAST_PC = PC_W'(33);
  localparam logic [TMP_W-1:0]  MAGMAX  = '1;
  localparam logic [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [FIELD_W-1:0] GRAV_RST  = 48'hFFCD_3800_0000;
  localparam logic [UMAG_W-1:0]  VGAIN_RST = 47'h0046_5000_0000;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_KCOEF  = 3'd1;
  localparam logic [2:0] REG_GRAV   = 3'd2;
  localparam logic [2:0] REG_VGAIN  = 3'd3;
  localparam logic [2:0] REG_INCL   = 3'd4;

  localparam int FLAG_SAT  = 0;
  localparam int FLAG_DENS = 1;

  typedef enum logic [2:0] {
    OP_SQ0, OP_SQ1, OP_SQRT, OP_MULQ, OP_DIV, OP_ACC, OP_NEG, OP_OUT
  } op_t;

  typedef enum logic [1:0] {C_RHO, C_PRS, C_VIS, C_LAST} cond_t;

  typedef enum logic [4:0] {
    SRC_MASS, SRC_PSUM, SRC_RHO, SRC_RHO2, SRC_KCOEF, SRC_DX, SRC_DY, SRC_VX, SRC_VY,
    SRC_R, SRC_D, SRC_VGAIN, SRC_SVX, SRC_SVY, SRC_RHOOWN, SRC_GRAV,
    SRC_T0, SRC_T1, SRC_T2
  } src_t;

  typedef enum logic [1:0] {T0, T1, T2} tmp_t;

  typedef enum logic [2:0] {S_PSX, S_PSY, S_VSX, S_VSY, S_FX, S_FY} sum_t;

  typedef enum logic [2:0] {
    G_NOT_NX, G_NOT_NY, G_NVX, G_NVY, G_SVX, G_SVY, G_GRAV
  } sgn_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    src_t  a;
    src_t  b;
    tmp_t  dst;
    sum_t  sdst;
    sgn_t  sgn;
  } uop_t;

  typedef struct packed {
    logic load;
    logic start;
    logic exec;
    uop_t u;
  } cmd_t;

  typedef struct packed {
    logic rho_nz;
    logic vis_ok;
    logic prs_ok;
    logic last;
    logic done;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [UMAG_W-1:0]  radius;
    logic [TMP_W-1:0]   kcoef;
    logic [FIELD_W-1:0] grav;
    logic [UMAG_W-1:0]  vgain;
    logic               incl;
  } cfg_t;

  function automatic uop_t mk_uop(input op_t op, input cond_t c, input src_t a,
                                  input src_t b, input tmp_t dst, input sum_t s,
                                  input sgn_t g);
    uop_t u;
    u.op   = op;
    u.cond = c;
    u.a    = a;
    u.b    = b;
    u.dst  = dst;
    u.sdst = s;
    u.sgn  = g;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk_uop(OP_SQ0,  C_RHO,  SRC_DX,     SRC_DX,    T0, S_PSX, G_NOT_NX);
      6'd1:  u = mk_uop(OP_SQ1,  C_RHO,  SRC_DY,     SRC_DY,    T0, S_PSX, G_NOT_NX);
      6'd2:  u = mk_uop(OP_SQRT, C_RHO,  SRC_DX,     SRC_DX,    T0, S_PSX, G_NOT_NX);
      6'd3:  u = mk_uop(OP_MULQ, C_PRS,  SRC_D,      SRC_D,     T0, S_PSX, G_NOT_NX);
      6'd4:  u = mk_uop(OP_MULQ, C_PRS,  SRC_MASS,   SRC_PSUM,  T1, S_PSX, G_NOT_NX);
      6'd5:  u = mk_uop(OP_DIV,  C_PRS,  SRC_T1,     SRC_RHO2,  T1, S_PSX, G_NOT_NX);
      6'd6:  u = mk_uop(OP_MULQ, C_PRS,  SRC_T1,     SRC_KCOEF, T1, S_PSX, G_NOT_NX);
      6'd7:  u = mk_uop(OP_DIV,  C_PRS,  SRC_DX,     SRC_R,     T2, S_PSX, G_NOT_NX);
      6'd8:  u = mk_uop(OP_MULQ, C_PRS,  SRC_T1,     SRC_T2,    T2, S_PSX, G_NOT_NX);
      6'd9:  u = mk_uop(OP_MULQ, C_PRS,  SRC_T2,     SRC_T0,    T2, S_PSX, G_NOT_NX);
      6'd10: u = mk_uop(OP_ACC,  C_PRS,  SRC_T2,     SRC_T2,    T2, S_PSX, G_NOT_NX);
      6'd11: u = mk_uop(OP_DIV,  C_PRS,  SRC_DY,     SRC_R,     T2, S_PSY, G_NOT_NY);
      6'd12: u = mk_uop(OP_MULQ, C_PRS,  SRC_T1,     SRC_T2,    T2, S_PSY, G_NOT_NY);
      6'd13: u = mk_uop(OP_MULQ, C_PRS,  SRC_T2,     SRC_T0,    T2, S_PSY, G_NOT_NY);
      6'd14: u = mk_uop(OP_ACC,  C_PRS,  SRC_T2,     SRC_T2,    T2, S_PSY, G_NOT_NY);
      6'd15: u = mk_uop(OP_MULQ, C_VIS,  SRC_MASS,   SRC_VX,    T1, S_VSX, G_NVX);
      6'd16: u = mk_uop(OP_DIV,  C_VIS,  SRC_T1,     SRC_RHO,   T1, S_VSX, G_NVX);
      6'd17: u = mk_uop(OP_MULQ, C_VIS,  SRC_T1,     SRC_KCOEF, T1, S_VSX, G_NVX);
      6'd18: u = mk_uop(OP_MULQ, C_VIS,  SRC_T1,     SRC_D,     T1, S_VSX, G_NVX);
      6'd19: u = mk_uop(OP_ACC,  C_VIS,  SRC_T1,     SRC_T1,    T1, S_VSX, G_NVX);
      6'd20: u = mk_uop(OP_MULQ, C_VIS,  SRC_MASS,   SRC_VY,    T1, S_VSY, G_NVY);
      6'd21: u = mk_uop(OP_DIV,  C_VIS,  SRC_T1,     SRC_RHO,   T1, S_VSY, G_NVY);
      6'd22: u = mk_uop(OP_MULQ, C_VIS,  SRC_T1,     SRC_KCOEF, T1, S_VSY, G_NVY);
      6'd23: u = mk_uop(OP_MULQ, C_VIS,  SRC_T1,     SRC_D,     T1, S_VSY, G_NVY);
      6'd24: u = mk_uop(OP_ACC,  C_VIS,  SRC_T1,     SRC_T1,    T1, S_VSY, G_NVY);
      6'd25: u = mk_uop(OP_NEG,  C_LAST, SRC_T1,     SRC_T1,    T1, S_FX,  G_SVX);
      6'd26: u = mk_uop(OP_MULQ, C_LAST, SRC_VGAIN,  SRC_SVX,   T1, S_FX,  G_SVX);
      6'd27: u = mk_uop(OP_ACC,  C_LAST, SRC_T1,     SRC_T1,    T1, S_FX,  G_SVX);
      6'd28: u = mk_uop(OP_NEG,  C_LAST, SRC_T1,     SRC_T1,    T1, S_FY,  G_SVY);
      6'd29: u = mk_uop(OP_MULQ, C_LAST, SRC_VGAIN,  SRC_SVY,   T1, S_FY,  G_SVY);
      6'd30: u = mk_uop(OP_ACC,  C_LAST, SRC_T1,     SRC_T1,    T1, S_FY,  G_SVY);
      6'd31: u = mk_uop(OP_MULQ, C_LAST, SRC_RHOOWN, SRC_GRAV,  T1, S_FY,  G_GRAV);
      6'd32: u = mk_uop(OP_ACC,  C_LAST, SRC_T1,     SRC_T1,    T1, S_FY,  G_GRAV);
      default: u = mk_uop(OP_OUT, C_LAST, SRC_T1,    SRC_T1,    T1, S_FY,  G_GRAV);
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/spf_mul.sv -----
// Multi-cycle 64x64 unsigned multiplier built from four 32x32 partial products.
// Depends on spf_pkg for widths.
module spf_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [spf_pkg::OPD_W-1:0] a,
  input  logic [spf_pkg::OPD_W-1:0] b,
  output logic                      done,
  output logic [spf_pkg::PROD_W-1:0] prod
);
  import spf_pkg::*;

  localparam int HALF = OPD_W / 2;

  logic                busy_r;
  logic                done_r;
  logic [2:0]          cnt_r;
  logic [OPD_W-1:0]    a_r;
  logic [OPD_W-1:0]    b_r;
  logic [OPD_W-1:0]    pp_r;
  logic [1:0]          sh_r;
  logic [PROD_W-1:0]   acc_r;
  logic [HALF-1:0]     ah;
  logic [HALF-1:0]     bh;

  assign ah   = cnt_r[1] ? a_r[OPD_W-1:HALF] : a_r[HALF-1:0];
  assign bh   = cnt_r[0] ? b_r[OPD_W-1:HALF] : b_r[HALF-1:0];
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      pp_r <= ah * bh;
      sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      if (cnt_r != 3'd0) begin
        acc_r <= acc_r + ({{(PROD_W-OPD_W){1'b0}}, pp_r} << {sh_r, 5'd0});
      end
    end
  end

endmodule

// ----- hw/rtl/spf_div.sv -----
// Restoring fixed-point divider, one quotient bit per cycle: floor(a * 2^FRAC / b).
// Depends on spf_pkg for widths.
module spf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [spf_pkg::TMP_W-1:0] a,
  input  logic [spf_pkg::OPD_W-1:0] b,
  output logic                      done,
  output logic [spf_pkg::QUO_W-1:0] quo
);
  import spf_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [QUO_W-1:0] num_r;
  logic [QUO_W-1:0] q_r;
  logic [OPD_W-1:0] rem_r;
  logic [OPD_W-1:0] b_r;
  logic [OPD_W:0]   rem_sh;
  logic [OPD_W:0]   rem_n;
  logic             ge;

  assign rem_sh = {rem_r, num_r[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, b_r};
  assign rem_n  = ge ? rem_sh - {1'b0, b_r} : rem_sh;
  assign done   = done_r;
  assign quo    = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {a, {FRAC{1'b0}}};
      rem_r <= '0;
      q_r   <= '0;
      b_r   <= b;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_n[OPD_W-1:0];
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/spf_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on spf_pkg for widths.
module spf_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [spf_pkg::RAD_W-1:0]  rad,
  output logic                       done,
  output logic [spf_pkg::ROOT_W-1:0] root
);
  import spf_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 2;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_n;
  logic             ge;

  assign rem_sh = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign rem_n  = ge ? rem_sh - trial : rem_sh;
  assign done   = done_r;
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_n[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/spf_ctrl.sv -----
// Micro-op sequencer: steps through the micro-op table for each pair transaction.
// Depends on spf_pkg for the table, command and status types.
module spf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spf_pkg::sts_t sts,
  output spf_pkg::cmd_t cmd
);
  import spf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  uop_t            u;
  logic            cond_ok;
  logic            multi;

  assign u        = uop_rom(pc_r);
  assign in_stall = (state_r != ST_IDLE);
  assign multi    = (u.op == OP_SQ0) || (u.op == OP_SQ1) || (u.op == OP_SQRT) ||
                    (u.op == OP_MULQ) || (u.op == OP_DIV);

  always_comb begin
    case (u.cond)
      C_RHO:   cond_ok = sts.rho_nz;
      C_PRS:   cond_ok = sts.prs_ok;
      C_VIS:   cond_ok = sts.vis_ok;
      C_LAST:  cond_ok = sts.last;
      default: cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    logic adv;
    adv       = 1'b0;
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cmd.load  = 1'b0;
    cmd.start = 1'b0;
    cmd.exec  = 1'b0;
    cmd.u     = u;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
          pc_nxt    = '0;
        end
      end
      ST_EXEC: begin
        if (!cond_ok) begin
          adv = 1'b1;
        end else if (multi) begin
          cmd.start = 1'b1;
          state_nxt = ST_WAIT;
        end else if (u.op == OP_OUT) begin
          if (!sts.out_busy) begin
            cmd.exec = 1'b1;
            adv      = 1'b1;
          end
        end else begin
          cmd.exec = 1'b1;
          adv      = 1'b1;
        end
      end
      ST_WAIT: begin
        if (sts.done) begin
          adv = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pc_nxt    = '0;
      end
    endcase
    if (adv) begin
      if (pc_r == LAST_PC) begin
        state_nxt = ST_IDLE;
        pc_nxt    = '0;
      end else begin
        state_nxt = ST_EXEC;
        pc_nxt    = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_wait_multi: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> multi)
    else $error("waiting on a single-cycle micro-op");

  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pc_r == '0))
    else $error("idle with nonzero micro-op pointer");
`endif

endmodule

// ----- hw/rtl/spf_dp.sv -----
// Datapath: operand registers, temporaries, sums, arithmetic units, output register.
// Depends on spf_pkg, spf_mul, spf_div and spf_sqrt.
module spf_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  spf_pkg::cmd_t               cmd,
  output spf_pkg::sts_t               sts,
  input  spf_pkg::cfg_t               cfg,
  input  logic [spf_pkg::FIELD_W-1:0] in_offset_x,
  input  logic [spf_pkg::FIELD_W-1:0] in_offset_y,
  input  logic [spf_pkg::UMAG_W-1:0]  in_neighbour_mass,
  input  logic [spf_pkg::UMAG_W-1:0]  in_own_pressure,
  input  logic [spf_pkg::UMAG_W-1:0]  in_neighbour_pressure,
  input  logic [spf_pkg::UMAG_W-1:0]  in_neighbour_density,
  input  logic [spf_pkg::FIELD_W-1:0] in_vel_diff_x,
  input  logic [spf_pkg::FIELD_W-1:0] in_vel_diff_y,
  input  logic [spf_pkg::UMAG_W-1:0]  in_own_density,
  input  logic                        in_last_pair,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spf_pkg::ACC_W-1:0]   out_force_x,
  output logic [spf_pkg::ACC_W-1:0]   out_force_y,
  output logic [spf_pkg::FLAG_W-1:0]  out_flags
);
  import spf_pkg::*;

  function automatic logic [FIELD_W-1:0] smag(input logic [FIELD_W-1:0] v);
    return v[FIELD_W-1] ? (~v + FIELD_W'(1)) : v;
  endfunction

  function automatic logic [ACC_W-1:0] amag(input logic [ACC_W-1:0] v);
    return v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
  endfunction

  logic [FIELD_W-1:0] dxm_r, dym_r, vxm_r, vym_r;
  logic               nx_r, ny_r, nvx_r, nvy_r, last_r;
  logic [UMAG_W-1:0]  mass_r, pi_r, pj_r, rho_r, rho_own_r;
  logic [RAD_W-1:0]   rad_r;
  logic [ROOT_W-1:0]  r_r;
  logic [TMP_W-1:0]   t0_r, t1_r, t2_r;
  logic [ACC_W-1:0]   psx_r, psy_r, vsx_r, vsy_r, fx_r, fy_r;
  logic [FLAG_W-1:0]  sticky_r;
  logic               out_valid_r;
  logic [ACC_W-1:0]   out_fx_r, out_fy_r;
  logic [FLAG_W-1:0]  out_flags_r;

  logic [OPD_W-1:0]   opa, opb;
  logic               in_range;
  logic [UMAG_W-1:0]  d;
  logic               mul_start, div_start, sqrt_start;
  logic               mul_done, div_done, sqrt_done;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  logic [ROOT_W-1:0]  root;
  logic               mq_ovf, dq_ovf;
  logic [TMP_W-1:0]   mq_val, dq_val, res_val;
  logic               wb;
  logic               exec_acc, exec_neg, exec_out;
  logic [ACC_W-1:0]   s_cur, term, acc_res, neg_src, neg_res;
  logic [ACC_W:0]     sum_ext;
  logic               g_neg, acc_ovf, neg_min, sat_ev;

  function automatic logic [OPD_W-1:0] sel(input src_t s);
    logic [OPD_W-1:0] v;
    case (s)
      SRC_MASS:   v = OPD_W'(mass_r);
      SRC_PSUM:   v = OPD_W'({1'b0, pi_r} + {1'b0, pj_r});
      SRC_RHO:    v = OPD_W'(rho_r);
      SRC_RHO2:   v = OPD_W'({rho_r, 1'b0});
      SRC_KCOEF:  v = OPD_W'(cfg.kcoef);
      SRC_DX:     v = OPD_W'(dxm_r);
      SRC_DY:     v = OPD_W'(dym_r);
      SRC_VX:     v = OPD_W'(vxm_r);
      SRC_VY:     v = OPD_W'(vym_r);
      SRC_R:      v = OPD_W'(r_r);
      SRC_D:      v = OPD_W'(d);
      SRC_VGAIN:  v = OPD_W'(cfg.vgain);
      SRC_SVX:    v = amag(vsx_r);
      SRC_SVY:    v = amag(vsy_r);
      SRC_RHOOWN: v = OPD_W'(rho_own_r);
      SRC_GRAV:   v = OPD_W'(smag(cfg.grav));
      SRC_T0:     v = OPD_W'(t0_r);
      SRC_T1:     v = OPD_W'(t1_r);
      SRC_T2:     v = OPD_W'(t2_r);
      default:    v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = sel(cmd.u.a);
    opb = sel(cmd.u.b);
  end

  assign in_range = {1'b0, cfg.radius} >= r_r;
  assign d        = cfg.radius - r_r[UMAG_W-1:0];

  assign mul_start  = cmd.start && ((cmd.u.op == OP_SQ0) || (cmd.u.op == OP_SQ1) ||
                                    (cmd.u.op == OP_MULQ));
  assign div_start  = cmd.start && (cmd.u.op == OP_DIV);
  assign sqrt_start = cmd.start && (cmd.u.op == OP_SQRT);

  spf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .prod  (prod)
  );

  spf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (opa[TMP_W-1:0]),
    .b     (opb),
    .done  (div_done),
    .quo   (quo)
  );

  spf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (rad_r),
    .done  (sqrt_done),
    .root  (root)
  );

  assign mq_ovf  = |prod[PROD_W-1:TMP_W+FRAC];
  assign mq_val  = mq_ovf ? MAGMAX : prod[TMP_W+FRAC-1:FRAC];
  assign dq_ovf  = |quo[QUO_W-1:TMP_W];
  assign dq_val  = dq_ovf ? MAGMAX : quo[TMP_W-1:0];
  assign res_val = (cmd.u.op == OP_DIV) ? dq_val : mq_val;
  assign wb      = (mul_done && (cmd.u.op == OP_MULQ)) || div_done;

  assign exec_acc = cmd.exec && (cmd.u.op == OP_ACC);
  assign exec_neg = cmd.exec && (cmd.u.op == OP_NEG);
  assign exec_out = cmd.exec && (cmd.u.op == OP_OUT);

  always_comb begin
    case (cmd.u.sdst)
      S_PSX:   s_cur = psx_r;
      S_PSY:   s_cur = psy_r;
      S_VSX:   s_cur = vsx_r;
      S_VSY:   s_cur = vsy_r;
      S_FX:    s_cur = fx_r;
      S_FY:    s_cur = fy_r;
      default: s_cur = '0;
    endcase
    case (cmd.u.sgn)
      G_NOT_NX: g_neg = !nx_r;
      G_NOT_NY: g_neg = !ny_r;
      G_NVX:    g_neg = nvx_r;
      G_NVY:    g_neg = nvy_r;
      G_SVX:    g_neg = vsx_r[ACC_W-1];
      G_SVY:    g_neg = vsy_r[ACC_W-1];
      G_GRAV:   g_neg = cfg.grav[FIELD_W-1];
      default:  g_neg = 1'b0;
    endcase
  end

  assign term    = g_neg ? (~ACC_W'(opa[TMP_W-1:0]) + ACC_W'(1)) : ACC_W'(opa[TMP_W-1:0]);
  assign sum_ext = {s_cur[ACC_W-1], s_cur} + {term[ACC_W-1], term};
  assign acc_ovf = sum_ext[ACC_W] != sum_ext[ACC_W-1];
  assign acc_res = acc_ovf ? (sum_ext[ACC_W] ? ACC_MIN : ACC_MAX) : sum_ext[ACC_W-1:0];

  assign neg_src = (cmd.u.sdst == S_FX) ? psx_r : psy_r;
  assign neg_min = (neg_src == ACC_MIN);
  assign neg_res = neg_min ? ACC_MAX : (~neg_src + ACC_W'(1));

  assign sat_ev = (mul_done && (cmd.u.op == OP_MULQ) && mq_ovf) || (div_done && dq_ovf) ||
                  (exec_acc && acc_ovf) || (exec_neg && neg_min);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dxm_r     <= smag(in_offset_x);
      nx_r      <= in_offset_x[FIELD_W-1];
      dym_r     <= smag(in_offset_y);
      ny_r      <= in_offset_y[FIELD_W-1];
      vxm_r     <= smag(in_vel_diff_x);
      nvx_r     <= in_vel_diff_x[FIELD_W-1];
      vym_r     <= smag(in_vel_diff_y);
      nvy_r     <= in_vel_diff_y[FIELD_W-1];
      mass_r    <= in_neighbour_mass;
      pi_r      <= in_own_pressure;
      pj_r      <= in_neighbour_pressure;
      rho_r     <= in_neighbour_density;
      rho_own_r <= in_own_density;
      last_r    <= in_last_pair;
    end
    if (mul_done && (cmd.u.op == OP_SQ0)) begin
      rad_r <= prod[RAD_W-1:0];
    end
    if (mul_done && (cmd.u.op == OP_SQ1)) begin
      rad_r <= rad_r + prod[RAD_W-1:0];
    end
    if (sqrt_done) begin
      r_r <= root;
    end
    if (wb) begin
      case (cmd.u.dst)
        T0:      t0_r <= res_val;
        T1:      t1_r <= res_val;
        T2:      t2_r <= res_val;
        default: t2_r <= res_val;
      endcase
    end
    if (exec_out) begin
      out_fx_r    <= fx_r;
      out_fy_r    <= fy_r;
      out_flags_r <= sticky_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psx_r       <= '0;
      psy_r       <= '0;
      vsx_r       <= '0;
      vsy_r       <= '0;
      fx_r        <= '0;
      fy_r        <= '0;
      sticky_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load && (in_neighbour_density == '0)) begin
        sticky_r[FLAG_DENS] <= 1'b1;
      end
      if (sat_ev) begin
        sticky_r[FLAG_SAT] <= 1'b1;
      end
      if (exec_acc || exec_neg) begin
        case (cmd.u.sdst)
          S_PSX:   psx_r <= acc_res;
          S_PSY:   psy_r <= acc_res;
          S_VSX:   vsx_r <= acc_res;
          S_VSY:   vsy_r <= acc_res;
          S_FX:    fx_r  <= exec_neg ? neg_res : acc_res;
          S_FY:    fy_r  <= exec_neg ? neg_res : acc_res;
          default: fy_r  <= fy_r;
        endcase
      end
      if (exec_out) begin
        out_valid_r <= 1'b1;
        psx_r       <= '0;
        psy_r       <= '0;
        vsx_r       <= '0;
        vsy_r       <= '0;
        sticky_r    <= '0;
      end
    end
  end

  assign sts.rho_nz   = (rho_r != '0);
  assign sts.vis_ok   = (rho_r != '0) && in_range;
  assign sts.prs_ok   = (rho_r != '0) && in_range && cfg.incl && (r_r != '0);
  assign sts.last     = last_r;
  assign sts.done     = mul_done || div_done || sqrt_done;
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid   = out_valid_r;
  assign out_force_x = out_fx_r;
  assign out_force_y = out_fy_r;
  assign out_flags   = out_flags_r;

`ifndef ASSERT_OFF
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_done, div_done, sqrt_done}))
    else $error("two arithmetic units finished together");

  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    exec_out |=> (psx_r == '0) && (psy_r == '0) && (vsx_r == '0) && (vsy_r == '0) &&
                 (sticky_r == '0))
    else $error("sums not cleared after result");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    exec_out |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while held");
`endif

endmodule

// ----- hw/rtl/sph_pair_force_accumulator.sv -----
// SPH pair force accumulator: per-pair spiky pressure and viscosity sums, force on last pair.
// Depends on spf_pkg, spf_ctrl and spf_dp; holds the configuration registers.
//
// One neighbour pair is taken per transaction; the block accepts a pair only when the
// previous one has finished its micro-op sequence. A pair in range with the pressure term
// runs five divisions on the one-bit-per-cycle divider, the square root and fifteen
// multiplies on the shared 32x32 multiplier, plus a step for each accumulate and each
// skipped micro-op; a pair in range without the pressure term skips the pressure steps,
// an out-of-range pair also skips the viscosity steps, and a pair with zero neighbour
// density also the distance steps. The last pair adds the steps for the final force and
// waits while a held result is stalled in the output register.
// A result waits in an output register, so the next pair is taken while it is held.
module sph_pair_force_accumulator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spf_pkg::ADDR_W-1:0]  paddr,
  input  logic [spf_pkg::DATA_W-1:0]  pwdata,
  output logic [spf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [spf_pkg::FIELD_W-1:0] in_offset_x,
  input  logic [spf_pkg::FIELD_W-1:0] in_offset_y,
  input  logic [spf_pkg::UMAG_W-1:0]  in_neighbour_mass,
  input  logic [spf_pkg::UMAG_W-1:0]  in_own_pressure,
  input  logic [spf_pkg::UMAG_W-1:0]  in_neighbour_pressure,
  input  logic [spf_pkg::UMAG_W-1:0]  in_neighbour_density,
  input  logic [spf_pkg::FIELD_W-1:0] in_vel_diff_x,
  input  logic [spf_pkg::FIELD_W-1:0] in_vel_diff_y,
  input  logic [spf_pkg::UMAG_W-1:0]  in_own_density,
  input  logic                        in_last_pair,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [spf_pkg::ACC_W-1:0]   out_force_x,
  output logic [spf_pkg::ACC_W-1:0]   out_force_y,
  output logic [spf_pkg::FLAG_W-1:0]  out_flags
);
  import spf_pkg::*;

  cfg_t       cfg_r;
  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= '0;
      cfg_r.kcoef  <= '0;
      cfg_r.grav   <= GRAV_RST;
      cfg_r.vgain  <= VGAIN_RST;
      cfg_r.incl   <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIUS: cfg_r.radius <= pwdata[UMAG_W-1:0];
        REG_KCOEF:  cfg_r.kcoef  <= pwdata[TMP_W-1:0];
        REG_GRAV:   cfg_r.grav   <= pwdata[FIELD_W-1:0];
        REG_VGAIN:  cfg_r.vgain  <= pwdata[UMAG_W-1:0];
        REG_INCL:   cfg_r.incl   <= pwdata[0];
        default:    cfg_r.incl   <= cfg_r.incl;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS: prdata = DATA_W'(cfg_r.radius);
      REG_KCOEF:  prdata = DATA_W'(cfg_r.kcoef);
      REG_GRAV:   prdata = DATA_W'(cfg_r.grav);
      REG_VGAIN:  prdata = DATA_W'(cfg_r.vgain);
      REG_INCL:   prdata = DATA_W'(cfg_r.incl);
      default:    prdata = '0;
    endcase
  end

  spf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spf_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg                   (cfg_r),
    .in_offset_x           (in_offset_x),
    .in_offset_y           (in_offset_y),
    .in_neighbour_mass     (in_neighbour_mass),
    .in_own_pressure       (in_own_pressure),
    .in_neighbour_pressure (in_neighbour_pressure),
    .in_neighbour_density  (in_neighbour_density),
    .in_vel_diff_x         (in_vel_diff_x),
    .in_vel_diff_y         (in_vel_diff_y),
    .in_own_density        (in_own_density),
    .in_last_pair          (in_last_pair),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_force_x           (out_force_x),
    .out_force_y           (out_force_y),
    .out_flags             (out_flags)
  );

endmodule
